[rtl/core/ray_box_slab_intersect_unit_defines.svh]
// Assertion macros shared by the ray/box slab test RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_UNIT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_UNIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RBSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rbsi_pkg.sv]
`timescale 1ns / 1ps
package rbsi_pkg;

    localparam logic [2:0] CFG_MIN_X    = 3'd0;
    localparam logic [2:0] CFG_MIN_Y    = 3'd1;
    localparam logic [2:0] CFG_MIN_Z    = 3'd2;
    localparam logic [2:0] CFG_MAX_X    = 3'd3;
    localparam logic [2:0] CFG_MAX_Y    = 3'd4;
    localparam logic [2:0] CFG_MAX_Z    = 3'd5;
    localparam logic [2:0] CFG_MIN_DIST = 3'd6;

    localparam logic [2:0] FACE_NX = 3'd0;
    localparam logic [2:0] FACE_NY = 3'd1;
    localparam logic [2:0] FACE_NZ = 3'd2;
    localparam logic [2:0] FACE_PX = 3'd3;
    localparam logic [2:0] FACE_PY = 3'd4;
    localparam logic [2:0] FACE_PZ = 3'd5;

    localparam logic [30:0] MIN_DIST_RST = 31'd7;
    localparam logic [30:0] DIST_MAX     = 31'h7FFF_FFFF;

    // per-ray data carried alongside the divider lanes
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0]       neg;      // direction negative
        logic [2:0]       unb;      // origin inside slab
        logic [2:0]       flip_lo;  // quotient negative, min plane
        logic [2:0]       flip_hi;  // quotient negative, max plane
        logic             zmiss;    // zero direction outside slab
    } t_side;

endpackage

[rtl/core/rbsi_div_pipe.sv]
`timescale 1ns / 1ps
module rbsi_div_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [5:0][31:0]           i_num,
    input  logic [2:0][31:0]           i_den,
    input  rbsi_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [5:0][32+FRAC_BITS-1:0] o_quo,
    output rbsi_pkg::t_side            o_side
);
    import rbsi_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    logic                 r_v    [0:DW];
    logic [5:0][31:0]     r_rem  [0:DW];
    logic [5:0][DW-1:0]   r_q    [0:DW];
    logic [2:0][31:0]     r_den  [0:DW];
    t_side                r_side [0:DW];

    logic [5:0][31:0]     n_rem  [1:DW];
    logic [5:0][DW-1:0]   n_q    [1:DW];

    genvar s, l;
    generate
        for (s = 1; s <= DW; s++) begin : g_stage
            for (l = 0; l < 6; l++) begin : g_lane
                logic [32:0] trial;
                logic [32:0] diff;
                always_comb begin
                    trial = {r_rem[s-1][l], r_q[s-1][l][DW-1]};
                    diff  = trial - {1'b0, r_den[s-1][l % 3]};
                    if (!diff[32]) begin
                        n_rem[s][l] = diff[31:0];
                        n_q[s][l]   = {r_q[s-1][l][DW-2:0], 1'b1};
                    end else begin
                        n_rem[s][l] = trial[31:0];
                        n_q[s][l]   = {r_q[s-1][l][DW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= DW; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 6; m++) begin
                r_rem[0][m] <= '0;
                r_q[0][m]   <= {i_num[m], {FRAC_BITS{1'b0}}};
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k <= DW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[DW];
    assign o_quo   = r_q[DW];
    assign o_side  = r_side[DW];

endmodule

[rtl/core/ray_box_slab_intersect_unit.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                 | Beat
// ---------+-----------+---------------------------+---------------------------------
// ray      | in        | i_valid / o_ready         | i_origin_x/y/z, i_dir_x/y/z
// result   | out       | o_valid / i_ready         | o_hit_flag .. o_point_z
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One ray per cycle while the output is not stalled; data are Q16.16 at FRAC_BITS = 16.
// The divider is radix-2: one quotient bit per stage, 32 + FRAC_BITS stages.
// Reset: synchronous, active low; clears valid bits, loads the unit box and epsilon 7.
// Stall: the whole pipe holds while the output beat waits; o_ready = !o_valid | i_ready.
// Config is always ready; write only while the pipe is empty.
module ray_box_slab_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit_flag,
    output logic [30:0]        o_hit_distance,
    output logic [2:0]         o_face_index,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rbsi_pkg::*;
    `include "ray_box_slab_intersect_unit_defines.svh"

    localparam int DW = 32 + FRAC_BITS;
    localparam int TW = DW + 2;
    localparam logic signed [31:0]   ONE_FX     = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [TW-1:0] T_UNB      = TW'(64'd1 << DW);
    localparam logic signed [TW-1:0] DIST_MAX_T = TW'(64'h7FFF_FFFF);
    localparam logic [2:0] FACE_LO [3] = '{FACE_NX, FACE_NY, FACE_NZ};
    localparam logic [2:0] FACE_HI [3] = '{FACE_PX, FACE_PY, FACE_PZ};

    logic en;
    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    // configuration
    logic signed [31:0] r_bmin [3];
    logic signed [31:0] r_bmax [3];
    logic [30:0]        r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_bmin[a] <= -ONE_FX;
                r_bmax[a] <= ONE_FX;
            end
            r_eps <= MIN_DIST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_X:    r_bmin[0] <= i_cfg_data;
                CFG_MIN_Y:    r_bmin[1] <= i_cfg_data;
                CFG_MIN_Z:    r_bmin[2] <= i_cfg_data;
                CFG_MAX_X:    r_bmax[0] <= i_cfg_data;
                CFG_MAX_Y:    r_bmax[1] <= i_cfg_data;
                CFG_MAX_Z:    r_bmax[2] <= i_cfg_data;
                CFG_MIN_DIST: r_eps     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // input register
    logic               r_s0_vld;
    logic signed [31:0] r_s0_org [3];
    logic signed [31:0] r_s0_dir [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s0_vld <= 1'b0;
        else if (en)  r_s0_vld <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_org[0] <= i_origin_x;
            r_s0_org[1] <= i_origin_y;
            r_s0_org[2] <= i_origin_z;
            r_s0_dir[0] <= i_dir_x;
            r_s0_dir[1] <= i_dir_y;
            r_s0_dir[2] <= i_dir_z;
        end
    end

    // slab offsets, magnitudes and quotient signs
    logic [5:0][31:0] pre_num;
    logic [2:0][31:0] pre_den;
    t_side            pre_side;

    always_comb begin
        logic signed [32:0] dlo, dhi;
        logic               zero;
        pre_side.zmiss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            dlo = 33'(r_bmin[a]) - 33'(r_s0_org[a]);
            dhi = 33'(r_bmax[a]) - 33'(r_s0_org[a]);
            pre_num[a]     = dlo[32] ? 32'(-dlo) : dlo[31:0];
            pre_num[a + 3] = dhi[32] ? 32'(-dhi) : dhi[31:0];
            pre_den[a]     = r_s0_dir[a][31] ? 32'(-r_s0_dir[a]) : r_s0_dir[a];
            zero               = (r_s0_dir[a] == '0);
            pre_side.org[a]     = r_s0_org[a];
            pre_side.dir[a]     = r_s0_dir[a];
            pre_side.neg[a]     = r_s0_dir[a][31];
            pre_side.unb[a]     = (r_bmin[a] <= r_s0_org[a]) && (r_s0_org[a] <= r_bmax[a]);
            pre_side.flip_lo[a] = dlo[32] ^ r_s0_dir[a][31];
            pre_side.flip_hi[a] = dhi[32] ^ r_s0_dir[a][31];
            if (zero && !pre_side.unb[a]) pre_side.zmiss = 1'b1;
        end
    end

    logic               dv_vld;
    logic [5:0][DW-1:0] dv_quo;
    t_side              dv_side;

    rbsi_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_vld),
        .i_num   (pre_num),
        .i_den   (pre_den),
        .i_side  (pre_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // stage A: signed entry/exit per axis
    logic               r_a_vld;
    logic signed [TW-1:0] r_a_tin  [3];
    logic signed [TW-1:0] r_a_tout [3];
    t_side              r_a_side;
    logic signed [TW-1:0] n_a_tin  [3];
    logic signed [TW-1:0] n_a_tout [3];

    always_comb begin
        logic signed [TW-1:0] qlo, qhi;
        for (int a = 0; a < 3; a++) begin
            qlo = signed'({2'b00, dv_quo[a]});
            qhi = signed'({2'b00, dv_quo[a + 3]});
            if (dv_side.flip_lo[a]) qlo = -qlo;
            if (dv_side.flip_hi[a]) qhi = -qhi;
            if (dv_side.dir[a] == '0) begin
                n_a_tin[a]  = dv_side.unb[a] ? -T_UNB : '0;
                n_a_tout[a] = dv_side.unb[a] ? T_UNB : '0;
            end else begin
                n_a_tin[a]  = dv_side.neg[a] ? qhi : qlo;
                n_a_tout[a] = dv_side.neg[a] ? qlo : qhi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_tin  <= n_a_tin;
            r_a_tout <= n_a_tout;
            r_a_side <= dv_side;
        end
    end

    // stage B: largest entry, smallest exit
    logic                 r_b_vld;
    logic signed [TW-1:0] r_b_t0, r_b_t1;
    logic [2:0]           r_b_fin, r_b_fout;
    t_side                r_b_side;
    logic signed [TW-1:0] n_b_t0, n_b_t1;
    logic [2:0]           n_b_fin, n_b_fout;

    always_comb begin
        if (r_a_tin[0] > r_a_tin[1]) begin
            n_b_t0  = r_a_tin[0];
            n_b_fin = r_a_side.neg[0] ? FACE_HI[0] : FACE_LO[0];
        end else begin
            n_b_t0  = r_a_tin[1];
            n_b_fin = r_a_side.neg[1] ? FACE_HI[1] : FACE_LO[1];
        end
        if (r_a_tin[2] > n_b_t0) begin
            n_b_t0  = r_a_tin[2];
            n_b_fin = r_a_side.neg[2] ? FACE_HI[2] : FACE_LO[2];
        end
        if (r_a_tout[0] < r_a_tout[1]) begin
            n_b_t1   = r_a_tout[0];
            n_b_fout = r_a_side.neg[0] ? FACE_LO[0] : FACE_HI[0];
        end else begin
            n_b_t1   = r_a_tout[1];
            n_b_fout = r_a_side.neg[1] ? FACE_LO[1] : FACE_HI[1];
        end
        if (r_a_tout[2] < n_b_t1) begin
            n_b_t1   = r_a_tout[2];
            n_b_fout = r_a_side.neg[2] ? FACE_LO[2] : FACE_HI[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_t0   <= n_b_t0;
            r_b_t1   <= n_b_t1;
            r_b_fin  <= n_b_fin;
            r_b_fout <= n_b_fout;
            r_b_side <= r_a_side;
        end
    end

    // stage C: hit decision, distance pick and clamp
    logic               r_c_vld;
    logic               r_c_hit;
    logic [30:0]        r_c_t;
    logic [2:0]         r_c_face;
    t_side              r_c_side;
    logic               n_c_hit;
    logic [30:0]        n_c_t;
    logic [2:0]         n_c_face;

    always_comb begin
        logic signed [TW-1:0] eps_t, t_sel;
        eps_t   = signed'({{(TW-31){1'b0}}, r_eps});
        n_c_hit = !r_b_side.zmiss && (r_b_t0 < r_b_t1) && (r_b_t1 > eps_t);
        if (r_b_t0 > eps_t) begin
            t_sel    = r_b_t0;
            n_c_face = r_b_fin;
        end else begin
            t_sel    = r_b_t1;
            n_c_face = r_b_fout;
        end
        n_c_t = (t_sel > DIST_MAX_T) ? DIST_MAX : t_sel[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_hit  <= n_c_hit;
            r_c_t    <= n_c_t;
            r_c_face <= n_c_face;
            r_c_side <= r_b_side;
        end
    end

    // stage D: t * dir
    logic               r_d_vld;
    logic               r_d_hit;
    logic [30:0]        r_d_t;
    logic [2:0]         r_d_face;
    logic signed [63:0] r_d_prod [3];
    logic signed [31:0] r_d_org  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_hit  <= r_c_hit;
            r_d_t    <= r_c_t;
            r_d_face <= r_c_face;
            for (int a = 0; a < 3; a++) begin
                r_d_prod[a] <= 64'(signed'({1'b0, r_c_t})) * 64'(signed'(r_c_side.dir[a]));
                r_d_org[a]  <= r_c_side.org[a];
            end
        end
    end

    // stage E: floor shift, add origin, saturate; output register
    logic               r_o_hit;
    logic [30:0]        r_o_t;
    logic [2:0]         r_o_face;
    logic signed [31:0] r_o_pt [3];
    logic signed [31:0] n_o_pt [3];

    always_comb begin
        logic signed [63:0] sum;
        for (int a = 0; a < 3; a++) begin
            sum = 64'(r_d_org[a]) + (r_d_prod[a] >>> FRAC_BITS);
            if (sum > 64'sh7FFF_FFFF)       n_o_pt[a] = 32'sh7FFF_FFFF;
            else if (sum < -64'sh8000_0000) n_o_pt[a] = 32'sh8000_0000;
            else                            n_o_pt[a] = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hit  <= r_d_hit;
            r_o_t    <= r_d_hit ? r_d_t : '0;
            r_o_face <= r_d_hit ? r_d_face : FACE_NX;
            for (int a = 0; a < 3; a++) r_o_pt[a] <= r_d_hit ? n_o_pt[a] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_a_vld <= dv_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            o_valid <= r_d_vld;
        end
    end

    assign o_hit_flag     = r_o_hit;
    assign o_hit_distance = r_o_t;
    assign o_face_index   = r_o_face;
    assign o_point_x      = r_o_pt[0];
    assign o_point_y      = r_o_pt[1];
    assign o_point_z      = r_o_pt[2];

    logic miss_clean;
    assign miss_clean = (o_hit_distance == '0) && (o_face_index == FACE_NX)
                        && (o_point_x == '0) && (o_point_y == '0) && (o_point_z == '0);

    `RBSI_ASSERT_NOW(a_miss_zero, o_valid && !o_hit_flag, miss_clean, "nonzero miss beat")
    `RBSI_ASSERT_NOW(a_hit_dist, o_valid && o_hit_flag, o_hit_distance != '0, "hit at zero")
    `RBSI_ASSERT_NOW(a_face_range, o_valid && o_hit_flag, o_face_index <= FACE_PZ, "bad face")
    `RBSI_ASSERT_NEXT(a_stall_hold, o_valid && !i_ready && r_d_vld, r_d_vld && o_valid, "moved")

endmodule
